FILE: src/cncl_pkg.sv
// Shared constants and types for the cross neighbor max clamp block.
// Used by the channel interfaces and by every module of the block; depends on nothing.
package cncl_pkg;

   // Fixed widths of the channel fields and the configuration port.
   localparam int IDX_BITS       = 10;
   localparam int PIX_FIELD_BITS = 16;
   localparam int CFG_BITS       = 11;
   localparam int CSR_INDEX_BITS = 4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_COLS = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_ROWS = CSR_INDEX_BITS'(1);

   // Frame size after reset, in rows and in columns.
   localparam int FRAME_DIM_RESET = 8;

   // Defaults of the top level parameters.
   localparam int DEF_MAX_COLS   = 1024;
   localparam int DEF_MAX_ROWS   = 1024;
   localparam int DEF_PIXEL_BITS = 16;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;

   // One classified request: position, the operands of its windows and which
   // results it releases.
   typedef struct packed {
      logic [IDX_BITS-1:0]       row;
      logic [IDX_BITS-1:0]       col;
      logic [PIX_FIELD_BITS-1:0] pix;
      logic [PIX_FIELD_BITS-1:0] prev_c;
      logic [PIX_FIELD_BITS-1:0] prev_cm1;
      logic [PIX_FIELD_BITS-1:0] prev_cp1;
      logic [PIX_FIELD_BITS-1:0] older_c;
      logic [PIX_FIELD_BITS-1:0] cur_cm1;
      logic [PIX_FIELD_BITS-1:0] cur_cm2;
      logic                      row_gt0;
      logic                      row_gt1;
      logic                      col_gt0;
      logic                      col_gt1;
      logic                      row_last;
      logic                      col_last;
      logic                      emit_up;
      logic                      emit_left;
      logic                      emit_self;
   } entry_type;

endpackage

FILE: src/cncl_if.sv
// Valid/ready channel interfaces for the request and result streams.
// Depends on cncl_pkg for the field widths.
interface cncl_req_if;
   logic                                valid;
   logic                                ready;
   logic [cncl_pkg::PIX_FIELD_BITS-1:0] pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

interface cncl_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [cncl_pkg::IDX_BITS-1:0]       out_row;
   logic [cncl_pkg::IDX_BITS-1:0]       out_col;
   logic [cncl_pkg::PIX_FIELD_BITS-1:0] out_value;
   logic                                run_last;
   logic                                frame_done;

   modport source (output valid, output out_row, output out_col, output out_value,
                   output run_last, output frame_done, input ready);
   modport sink   (input valid, input out_row, input out_col, input out_value,
                   input run_last, input frame_done, output ready);
endinterface

FILE: src/cncl_front.sv
// Front of the block: frame size registers, raster position, three rotating line
// stores and the stage that gathers the operands of each request. Uses cncl_pkg, cncl_req_if.
module cncl_front #(
   parameter int MAX_COLS   = cncl_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS   = cncl_pkg::DEF_MAX_ROWS,
   parameter int PIXEL_BITS = cncl_pkg::DEF_PIXEL_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   cncl_req_if.sink                            req_if,
   input  logic                                csr_we,
   input  logic [cncl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cncl_pkg::CFG_BITS-1:0]       csr_wdata,
   input  logic [cncl_pkg::QUEUE_CNT_BITS-1:0] q_count,
   output logic                                push,
   output cncl_pkg::entry_type                 push_entry
);

   localparam int CIW        = $clog2(MAX_COLS);
   localparam int CNT_W      = $clog2(MAX_COLS + 1);
   localparam int RIW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int RCNT_W     = $clog2(MAX_ROWS + 1);
   localparam int PW         = (PIXEL_BITS < cncl_pkg::PIX_FIELD_BITS) ? PIXEL_BITS
                                                                       : cncl_pkg::PIX_FIELD_BITS;
   localparam int COLS_RESET = (cncl_pkg::FRAME_DIM_RESET > MAX_COLS) ? MAX_COLS
                                                                       : cncl_pkg::FRAME_DIM_RESET;
   localparam int ROWS_RESET = (cncl_pkg::FRAME_DIM_RESET > MAX_ROWS) ? MAX_ROWS
                                                                       : cncl_pkg::FRAME_DIM_RESET;
   localparam int NUM_BANKS  = 3;

   logic [CNT_W-1:0]  cols_ff, cols_in;
   logic [RCNT_W-1:0] rows_ff, rows_in;
   logic [CIW-1:0]    col_ff, col_in;
   logic [RIW-1:0]    row_ff, row_in;
   logic [1:0]        sel_ff, sel_in;
   logic [PW-1:0]     cur1_ff, cur2_ff;
   logic [PW-1:0]     prev_hold_ff;

   logic                s1_valid_ff;
   logic [1:0]          s1_sel_ff;
   cncl_pkg::entry_type s1_entry_ff;
   cncl_pkg::entry_type s1_entry_in;

   logic        acc;
   logic        cfg_hit;
   logic [31:0] wval;
   logic [31:0] cols_clamped;
   logic [31:0] rows_clamped;
   logic [CNT_W-1:0]  col_next;
   logic [RCNT_W-1:0] row_next;
   logic        col_last;
   logic        row_last;
   logic [PW-1:0] pix_w;
   logic [cncl_pkg::QUEUE_CNT_BITS-1:0] q_used;

   logic [PW-1:0] rd_a [NUM_BANKS];
   logic [PW-1:0] rd_b [NUM_BANKS];
   logic [PW-1:0] prev_c;
   logic [PW-1:0] prev_cp1;
   logic [PW-1:0] older_c;

   // Take a request only while the queue has room for it and for the one in flight.
   assign q_used       = q_count + cncl_pkg::QUEUE_CNT_BITS'(s1_valid_ff);
   assign req_if.ready = (q_used < cncl_pkg::QUEUE_CNT_BITS'(cncl_pkg::QUEUE_DEPTH));
   assign acc          = req_if.valid && req_if.ready;
   assign pix_w        = req_if.pixel_in[PW-1:0];

   // Frame size writes are clamped to the supported range; each such write restarts the frame.
   assign cfg_hit      = csr_we && (csr_index == cncl_pkg::REG_FRAME_COLS ||
                                    csr_index == cncl_pkg::REG_FRAME_ROWS);
   assign wval         = 32'(csr_wdata);
   assign cols_clamped = (wval == 32'd0) ? 32'd1 :
                         (wval > 32'(MAX_COLS)) ? 32'(MAX_COLS) : wval;
   assign rows_clamped = (wval == 32'd0) ? 32'd1 :
                         (wval > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : wval;

   // Position of the current request within the frame.
   assign col_next = CNT_W'(col_ff) + CNT_W'(1);
   assign row_next = RCNT_W'(row_ff) + RCNT_W'(1);
   assign col_last = (col_next == cols_ff);
   assign row_last = (row_next == rows_ff);

   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      sel_in  = sel_ff;
      if (acc) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : RIW'(row_next);
            sel_in = (sel_ff == 2'd2) ? 2'd0 : sel_ff + 2'd1;
         end else begin
            col_in = CIW'(col_next);
         end
      end
      if (csr_we && csr_index == cncl_pkg::REG_FRAME_COLS) begin
         cols_in = CNT_W'(cols_clamped);
      end
      if (csr_we && csr_index == cncl_pkg::REG_FRAME_ROWS) begin
         rows_in = RCNT_W'(rows_clamped);
      end
      if (cfg_hit) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff     <= CNT_W'(COLS_RESET);
         rows_ff     <= RCNT_W'(ROWS_RESET);
         col_ff      <= '0;
         row_ff      <= '0;
         sel_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         cols_ff     <= cols_in;
         rows_ff     <= rows_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         sel_ff      <= sel_in;
         s1_valid_ff <= acc;
      end
   end

   // Line stores: the bank of the current row is written, all banks are read at the
   // column and the one to its right; the roles rotate at every row end.
   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      logic [PW-1:0] line_mem [MAX_COLS];
      logic [PW-1:0] rd_a_ff;
      logic [PW-1:0] rd_b_ff;

      always_ff @(posedge clock) begin
         if (acc) begin
            if (sel_ff == 2'(b)) begin
               line_mem[col_ff] <= pix_w;
            end
            rd_a_ff <= line_mem[col_ff];
            rd_b_ff <= line_mem[CIW'(col_next)];
         end
      end

      assign rd_a[b] = rd_a_ff;
      assign rd_b[b] = rd_b_ff;
   end

   // Classification of the request and the position flags of its windows.
   always_comb begin
      s1_entry_in           = '0;
      s1_entry_in.row       = cncl_pkg::IDX_BITS'(row_ff);
      s1_entry_in.col       = cncl_pkg::IDX_BITS'(col_ff);
      s1_entry_in.pix       = cncl_pkg::PIX_FIELD_BITS'(pix_w);
      s1_entry_in.cur_cm1   = cncl_pkg::PIX_FIELD_BITS'(cur1_ff);
      s1_entry_in.cur_cm2   = cncl_pkg::PIX_FIELD_BITS'(cur2_ff);
      s1_entry_in.row_gt0   = (row_ff != '0);
      s1_entry_in.row_gt1   = (row_ff > RIW'(1));
      s1_entry_in.col_gt0   = (col_ff != '0);
      s1_entry_in.col_gt1   = (col_ff > CIW'(1));
      s1_entry_in.row_last  = row_last;
      s1_entry_in.col_last  = col_last;
      s1_entry_in.emit_up   = (row_ff != '0);
      s1_entry_in.emit_left = row_last && (col_ff != '0);
      s1_entry_in.emit_self = row_last && col_last;
   end

   // Last two pixels of the current row, and the registered classification.
   always_ff @(posedge clock) begin
      if (acc) begin
         cur1_ff     <= pix_w;
         cur2_ff     <= cur1_ff;
         s1_sel_ff   <= sel_ff;
         s1_entry_ff <= s1_entry_in;
      end
   end

   // Pick the previous and the older row out of the rotating banks.
   always_comb begin
      case (s1_sel_ff)
         2'd0: begin
            prev_c   = rd_a[2];
            prev_cp1 = rd_b[2];
            older_c  = rd_a[1];
         end
         2'd1: begin
            prev_c   = rd_a[0];
            prev_cp1 = rd_b[0];
            older_c  = rd_a[2];
         end
         default: begin
            prev_c   = rd_a[1];
            prev_cp1 = rd_b[1];
            older_c  = rd_a[0];
         end
      endcase
   end

   // The up-row pixel of this column becomes the left one for the next request.
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         prev_hold_ff <= prev_c;
      end
   end

   // Requests that release no result are dropped here.
   always_comb begin
      push_entry          = s1_entry_ff;
      push_entry.prev_c   = cncl_pkg::PIX_FIELD_BITS'(prev_c);
      push_entry.prev_cm1 = cncl_pkg::PIX_FIELD_BITS'(prev_hold_ff);
      push_entry.prev_cp1 = cncl_pkg::PIX_FIELD_BITS'(prev_cp1);
      push_entry.older_c  = cncl_pkg::PIX_FIELD_BITS'(older_c);
   end

   assign push = s1_valid_ff && (s1_entry_ff.emit_up || s1_entry_ff.emit_left ||
                                 s1_entry_ff.emit_self);

   // The last pixel of a frame brings the position back to the origin.
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      acc && row_last && col_last && !cfg_hit |=> row_ff == '0 && col_ff == '0)
      else $error("position did not wrap at frame end");

   // A frame size write restarts the frame.
   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      cfg_hit |=> row_ff == '0 && col_ff == '0)
      else $error("frame did not restart after a size write");

endmodule

FILE: src/cncl_queue.sv
// Short queue of classified requests between the front and the back.
// Uses cncl_pkg for the entry type and the depth.
module cncl_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  cncl_pkg::entry_type                 push_entry,
   input  logic                                pop,
   output cncl_pkg::entry_type                 head,
   output logic                                q_valid,
   output logic [cncl_pkg::QUEUE_CNT_BITS-1:0] q_count
);

   cncl_pkg::entry_type                 q_mem_ff [cncl_pkg::QUEUE_DEPTH];
   logic [cncl_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cncl_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cncl_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + cncl_pkg::QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + cncl_pkg::QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + cncl_pkg::QUEUE_CNT_BITS'(push)
                           - cncl_pkg::QUEUE_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head    = q_mem_ff[rd_ptr_ff];
   assign q_valid = (count_ff != '0);
   assign q_count = count_ff;

   // The front's credit check keeps the queue from overflowing.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff < cncl_pkg::QUEUE_CNT_BITS'(cncl_pkg::QUEUE_DEPTH))
      else $error("push into a full queue");

   // A pop only ever takes a stored entry.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from an empty queue");

endmodule

FILE: src/cncl_back.sv
// Back of the block: works through the results released by each queued request,
// computes the clamped value and holds it in the output register. Uses cncl_pkg, cncl_rsp_if.
module cncl_back (
   input  logic                clock,
   input  logic                reset,
   input  cncl_pkg::entry_type head,
   input  logic                q_valid,
   output logic                pop,
   cncl_rsp_if.source          rsp_if
);

   localparam int PXB = cncl_pkg::PIX_FIELD_BITS;
   localparam int IXB = cncl_pkg::IDX_BITS;

   logic [2:0] done_ff, done_in;
   logic       rsp_valid_ff;
   logic [IXB-1:0] out_row_ff;
   logic [IXB-1:0] out_col_ff;
   logic [PXB-1:0] out_value_ff;
   logic       run_last_ff;
   logic       frame_done_ff;

   logic [2:0] emit_mask;
   logic [2:0] pending;
   logic [2:0] pick;
   logic       last;
   logic       fire;

   logic [PXB-1:0] centre, up_v, dn_v, lf_v, rt_v;
   logic           up_ok, dn_ok, lf_ok, rt_ok;
   logic [IXB-1:0] res_row, res_col;
   logic [PXB-1:0] m_ud, m_lr, best, value;

   // Results of the head request in order: up row, left, self.
   assign emit_mask = {head.emit_self, head.emit_left, head.emit_up};
   assign pending   = emit_mask & ~done_ff;
   assign pick[0]   = pending[0];
   assign pick[1]   = pending[1] && !pending[0];
   assign pick[2]   = pending[2] && !pending[1] && !pending[0];
   assign last      = ((pending & ~pick) == 3'b000);
   assign fire      = q_valid && (!rsp_valid_ff || rsp_if.ready);
   assign pop       = fire && last;

   // Window operands of the chosen result.
   always_comb begin
      dn_v  = '0;
      dn_ok = 1'b0;
      rt_v  = '0;
      rt_ok = 1'b0;
      if (pick[0]) begin
         centre  = head.prev_c;
         up_v    = head.older_c;
         up_ok   = head.row_gt1;
         dn_v    = head.pix;
         dn_ok   = 1'b1;
         lf_v    = head.prev_cm1;
         lf_ok   = head.col_gt0;
         rt_v    = head.prev_cp1;
         rt_ok   = !head.col_last;
         res_row = head.row - IXB'(1);
         res_col = head.col;
      end else if (pick[1]) begin
         centre  = head.cur_cm1;
         up_v    = head.prev_cm1;
         up_ok   = head.row_gt0;
         lf_v    = head.cur_cm2;
         lf_ok   = head.col_gt1;
         rt_v    = head.pix;
         rt_ok   = 1'b1;
         res_row = head.row;
         res_col = head.col - IXB'(1);
      end else begin
         centre  = head.pix;
         up_v    = head.prev_c;
         up_ok   = head.row_gt0;
         lf_v    = head.cur_cm1;
         lf_ok   = head.col_gt0;
         res_row = head.row;
         res_col = head.col;
      end
   end

   // Largest existing neighbor, then the smaller of it and the center.
   always_comb begin
      logic [PXB-1:0] n_up, n_dn, n_lf, n_rt;
      n_up  = up_ok ? up_v : '0;
      n_dn  = dn_ok ? dn_v : '0;
      n_lf  = lf_ok ? lf_v : '0;
      n_rt  = rt_ok ? rt_v : '0;
      m_ud  = (n_dn > n_up) ? n_dn : n_up;
      m_lr  = (n_rt > n_lf) ? n_rt : n_lf;
      best  = (m_lr > m_ud) ? m_lr : m_ud;
      value = ((up_ok || dn_ok || lf_ok || rt_ok) && best < centre) ? best : centre;
   end

   // Results already sent for the head request.
   always_comb begin
      done_in = done_ff;
      if (pop) begin
         done_in = 3'b000;
      end else if (fire) begin
         done_in = done_ff | pick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= 3'b000;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         rsp_valid_ff <= fire || (rsp_valid_ff && !rsp_if.ready);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (fire) begin
         out_row_ff    <= res_row;
         out_col_ff    <= res_col;
         out_value_ff  <= value;
         run_last_ff   <= last;
         frame_done_ff <= last && head.row_last && head.col_last;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.out_row    = out_row_ff;
   assign rsp_if.out_col    = out_col_ff;
   assign rsp_if.out_value  = out_value_ff;
   assign rsp_if.run_last   = run_last_ff;
   assign rsp_if.frame_done = frame_done_ff;

   // A queued request always has a result left to send.
   a_head_pending: assert property (@(posedge clock) disable iff (reset)
      q_valid |-> pending != 3'b000)
      else $error("queued request with no result left");

   // The end of a frame is always the last result of its request.
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && frame_done_ff |-> run_last_ff)
      else $error("frame end flagged on a result that is not the last");

endmodule

FILE: src/cross_neighbor_max_clamp_core.sv
// A request passes the classification register of the front, the queue and the output register of the back.
// Throughput: one request per cycle while each releases at most one result and the
// output is ready; on the last row a request releases up to three, and the single result
// register sends one per cycle, so the four-entry queue fills and the request side waits.
// Reset: synchronous; the frame is set to 8 x 8 at the origin; line stores are not cleared.
module cross_neighbor_max_clamp_core #(
   parameter int MAX_COLS   = cncl_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS   = cncl_pkg::DEF_MAX_ROWS,
   parameter int PIXEL_BITS = cncl_pkg::DEF_PIXEL_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   cncl_req_if.sink                            req_if,
   cncl_rsp_if.source                          rsp_if,
   input  logic                                csr_we,
   input  logic [cncl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cncl_pkg::CFG_BITS-1:0]       csr_wdata
);

   logic                                push;
   cncl_pkg::entry_type                 push_entry;
   logic                                pop;
   cncl_pkg::entry_type                 head;
   logic                                q_valid;
   logic [cncl_pkg::QUEUE_CNT_BITS-1:0] q_count;

   // Request intake, position tracking and line stores.
   cncl_front #(
      .MAX_COLS   (MAX_COLS),
      .MAX_ROWS   (MAX_ROWS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_count    (q_count),
      .push       (push),
      .push_entry (push_entry)
   );

   // Decoupling queue.
   cncl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_valid    (q_valid),
      .q_count    (q_count)
   );

   // Result computation and output register.
   cncl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_valid    (q_valid),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule
